>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define GRST_ASSERT(lbl, pexpr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) pexpr) \
        else $error("gamepad tracker assertion failed");

// checked at every edge, reset included
`define GRST_ASSERT_ALWAYS(lbl, pexpr) \
    lbl: assert property (@(posedge i_clk) pexpr) \
        else $error("gamepad tracker assertion failed");

`endif

>>> rtl/grst_pkg.sv
// ----------------------------------------------------------------------------
// grst_pkg
// types and constants of the gamepad report state tracker
// ----------------------------------------------------------------------------
package grst_pkg;

    localparam int BUTTON_COUNT = 16;
    localparam int HELD_W       = 16;
    localparam int HELD_IDX_W   = $clog2(HELD_W);
    localparam int BTN_LIMIT    = (BUTTON_COUNT < HELD_W) ? BUTTON_COUNT : HELD_W;

    localparam logic [15:0] PAGE_DESKTOP = 16'h0001;
    localparam logic [15:0] PAGE_BUTTON  = 16'h0009;

    localparam logic [15:0] USAGE_X  = 16'h0030;
    localparam logic [15:0] USAGE_Y  = 16'h0031;
    localparam logic [15:0] USAGE_Z  = 16'h0032;
    localparam logic [15:0] USAGE_RX = 16'h0033;
    localparam logic [15:0] USAGE_RY = 16'h0034;
    localparam logic [15:0] USAGE_RZ = 16'h0035;
    localparam logic [15:0] USAGE_HAT = 16'h0039;

    localparam logic [7:0] AXIS_CENTER  = 8'h80;
    localparam logic [7:0] HAT_RELEASED = 8'h08;

    typedef enum logic [1:0] {
        FUNC_UPDATE = 2'd0,
        FUNC_READ   = 2'd1,
        FUNC_RESET  = 2'd2
    } t_func;

    typedef struct packed {
        logic [7:0]        left_x;
        logic [7:0]        left_y;
        logic [7:0]        right_x;
        logic [7:0]        right_y;
        logic [7:0]        trig_l;
        logic [7:0]        trig_r;
        logic [7:0]        hat;
        logic [HELD_W-1:0] held;
        logic [HELD_W-1:0] changed;
    } t_pad_state;

    localparam t_pad_state STATE_DEFAULT = '{
        left_x:  AXIS_CENTER,
        left_y:  AXIS_CENTER,
        right_x: AXIS_CENTER,
        right_y: AXIS_CENTER,
        trig_l:  8'h00,
        trig_r:  8'h00,
        hat:     HAT_RELEASED,
        held:    '0,
        changed: '0
    };

endpackage

>>> rtl/gamepad_report_state_tracker_unit.sv
// ----------------------------------------------------------------------------
// gamepad_report_state_tracker_unit
// gamepad state kept from decoded hid report fields
//
// Takes one beat per clock: an update (usage page, usage, value), a read that
// returns the state and then clears the changed bits, or a reset to defaults;
// an unused code returns the state unchanged. Each beat gives exactly one
// result beat, and a new beat is taken every cycle as long as results are
// drained; the input register and the result register each hold one beat, so
// one more beat is taken while a result waits. The throughput of one beat per
// cycle is set by the single state update between those two registers.
// ----------------------------------------------------------------------------
module gamepad_report_state_tracker_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_func,
    input  logic [15:0]        i_usage_page,
    input  logic [15:0]        i_usage,
    input  logic signed [31:0] i_field_value,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [7:0]         o_stick_left_x,
    output logic [7:0]         o_stick_left_y,
    output logic [7:0]         o_stick_right_x,
    output logic [7:0]         o_stick_right_y,
    output logic [7:0]         o_trigger_left,
    output logic [7:0]         o_trigger_right,
    output logic [7:0]         o_hat_direction,
    output logic [grst_pkg::HELD_W-1:0] o_buttons_held,
    output logic [grst_pkg::HELD_W-1:0] o_buttons_changed
);
    import grst_pkg::*;

    logic        r_in_valid;
    t_func       r_in_func;
    logic [15:0] r_in_page;
    logic [15:0] r_in_usage;
    logic [31:0] r_in_value;

    t_pad_state  r_state;
    t_pad_state  n_state;
    t_pad_state  r_res;
    t_pad_state  n_res;
    logic        r_out_valid;

    logic                  w_adv;
    logic                  w_btn_ok;
    logic                  w_pressed;
    logic [HELD_IDX_W-1:0] w_btn_idx;

    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = i_rst_n && (!r_in_valid || w_adv);

    assign w_btn_ok  = (r_in_usage != 16'd0) && (r_in_usage <= 16'(BTN_LIMIT));
    assign w_btn_idx = HELD_IDX_W'(r_in_usage - 16'd1);
    assign w_pressed = (r_in_value != 32'd0);

    always_comb begin
        n_state = r_state;
        n_res   = r_state;
        case (r_in_func)
            FUNC_UPDATE: begin
                if (r_in_page == PAGE_DESKTOP) begin
                    case (r_in_usage)
                        USAGE_X:   n_state.left_x  = r_in_value[7:0];
                        USAGE_Y:   n_state.left_y  = r_in_value[7:0];
                        USAGE_Z:   n_state.right_x = r_in_value[7:0];
                        USAGE_RX:  n_state.trig_l  = r_in_value[7:0];
                        USAGE_RY:  n_state.trig_r  = r_in_value[7:0];
                        USAGE_RZ:  n_state.right_y = r_in_value[7:0];
                        USAGE_HAT: n_state.hat     = r_in_value[7:0];
                        default: ;
                    endcase
                end else if (r_in_page == PAGE_BUTTON && w_btn_ok) begin
                    if (r_state.held[w_btn_idx] != w_pressed) begin
                        n_state.changed[w_btn_idx] = 1'b1;
                    end
                    n_state.held[w_btn_idx] = w_pressed;
                end
                n_res = n_state;
            end
            FUNC_READ: begin
                n_state.changed = '0;
            end
            FUNC_RESET: begin
                n_state = STATE_DEFAULT;
                n_res   = STATE_DEFAULT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_func  <= t_func'(i_func);
            r_in_page  <= i_usage_page;
            r_in_usage <= i_usage;
            r_in_value <= i_field_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= STATE_DEFAULT;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_state     <= n_state;
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_res <= n_res;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_stick_left_x    = r_res.left_x;
    assign o_stick_left_y    = r_res.left_y;
    assign o_stick_right_x   = r_res.right_x;
    assign o_stick_right_y   = r_res.right_y;
    assign o_trigger_left    = r_res.trig_l;
    assign o_trigger_right   = r_res.trig_r;
    assign o_hat_direction   = r_res.hat;
    assign o_buttons_held    = r_res.held;
    assign o_buttons_changed = r_res.changed;

endmodule

>>> rtl/grst_checker.sv
// ----------------------------------------------------------------------------
// grst_checker
// port-level checks of the gamepad report state tracker
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module grst_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic [7:0]  o_hat_direction,
    input logic [grst_pkg::HELD_W-1:0] o_buttons_held,
    input logic [grst_pkg::HELD_W-1:0] o_buttons_changed
);
    import grst_pkg::*;

    // stalled result beat holds
    `GRST_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_hat_direction))

    // stalled result beat keeps its button fields
    `GRST_ASSERT(a_out_data, o_valid && !i_ready |=> $stable({o_buttons_held, o_buttons_changed}))

    // reset leaves no result pending
    `GRST_ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> !o_valid)

    // input backpressure only from a stalled result
    `GRST_ASSERT(a_stall_cause, !o_ready |-> o_valid && !i_ready)

    // a drained output frees the input side
    `GRST_ASSERT(a_drain_ready, !o_valid |-> o_ready)

endmodule

bind gamepad_report_state_tracker_unit grst_checker u_grst_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_ready           (o_ready),
    .o_valid           (o_valid),
    .i_ready           (i_ready),
    .o_hat_direction   (o_hat_direction),
    .o_buttons_held    (o_buttons_held),
    .o_buttons_changed (o_buttons_changed)
);

>>> tb/sv/grst_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// grst_tb_pkg
// scoreboard for the gamepad report state tracker
//
// Tracks the pad state from every accepted input beat and queues the state
// that the matching result beat must carry, then checks result beats in order
// field by field.
// ----------------------------------------------------------------------------
package grst_tb_pkg;

    import grst_pkg::*;

    // func code the block has no operation for
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    class pad_scoreboard;
        t_pad_state pad;
        t_pad_state expected_q[$];
        int         mismatches;

        function new();
            pad        = STATE_DEFAULT;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_beat(logic [1:0] func, logic [15:0] page,
                                logic [15:0] usage, logic [31:0] value);
            int   idx;
            logic pressed;
            case (func)
                FUNC_UPDATE: begin
                    if (page == PAGE_DESKTOP) begin
                        case (usage)
                            USAGE_X:   pad.left_x  = value[7:0];
                            USAGE_Y:   pad.left_y  = value[7:0];
                            USAGE_Z:   pad.right_x = value[7:0];
                            USAGE_RX:  pad.trig_l  = value[7:0];
                            USAGE_RY:  pad.trig_r  = value[7:0];
                            USAGE_RZ:  pad.right_y = value[7:0];
                            USAGE_HAT: pad.hat     = value[7:0];
                            default: ;
                        endcase
                    end else if (page == PAGE_BUTTON) begin
                        pressed = (value != 32'd0);
                        if (usage != 16'd0 && usage <= BTN_LIMIT) begin
                            idx = int'(usage) - 1;
                            if (pad.held[idx] != pressed) pad.changed[idx] = 1'b1;
                            pad.held[idx] = pressed;
                        end
                    end
                    expected_q.push_back(pad);
                end
                FUNC_READ: begin
                    expected_q.push_back(pad);
                    pad.changed = '0;
                end
                FUNC_RESET: begin
                    pad = STATE_DEFAULT;
                    expected_q.push_back(pad);
                end
                default: expected_q.push_back(pad);
            endcase
        endfunction

        task report_mismatch(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endtask

        task check_field(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
        endtask

        task check_result(t_pad_state got);
            t_pad_state want;
            if (expected_q.size() == 0) begin
                report_mismatch("result beat with no input beat pending");
            end else begin
                want = expected_q.pop_front();
                check_field("stick_left_x",    got.left_x,  want.left_x);
                check_field("stick_left_y",    got.left_y,  want.left_y);
                check_field("stick_right_x",   got.right_x, want.right_x);
                check_field("stick_right_y",   got.right_y, want.right_y);
                check_field("trigger_left",    got.trig_l,  want.trig_l);
                check_field("trigger_right",   got.trig_r,  want.trig_r);
                check_field("hat_direction",   got.hat,     want.hat);
                check_field("buttons_held",    got.held,    want.held);
                check_field("buttons_changed", got.changed, want.changed);
            end
        endtask
    endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// testbench of the gamepad report state tracker
//
// Drives directed update, read, reset and unused-code beats, then mostly
// well-formed random report fields with some noise, under sender bursts and
// receiver stalls, including long receiver hold-offs and full drains. Every
// result beat is checked against the scoreboard's tracked state.
// ----------------------------------------------------------------------------
module tb_top;

    import grst_pkg::*;
    import grst_tb_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int RANDOM_BEATS = 700;
    localparam int HOLD_CYCLES  = 60;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [1:0]         i_func;
    logic [15:0]        i_usage_page;
    logic [15:0]        i_usage;
    logic signed [31:0] i_field_value;
    logic               o_valid;
    logic               i_ready;
    logic [7:0]         o_stick_left_x;
    logic [7:0]         o_stick_left_y;
    logic [7:0]         o_stick_right_x;
    logic [7:0]         o_stick_right_y;
    logic [7:0]         o_trigger_left;
    logic [7:0]         o_trigger_right;
    logic [7:0]         o_hat_direction;
    logic [HELD_W-1:0]  o_buttons_held;
    logic [HELD_W-1:0]  o_buttons_changed;

    pad_scoreboard sb = new();

    int burst_left    = 0;
    bit hold_active   = 0;
    int hold_requests = 0;
    int holds_done    = 0;

    gamepad_report_state_tracker_unit u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_func            (i_func),
        .i_usage_page      (i_usage_page),
        .i_usage           (i_usage),
        .i_field_value     (i_field_value),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_stick_left_x    (o_stick_left_x),
        .o_stick_left_y    (o_stick_left_y),
        .o_stick_right_x   (o_stick_right_x),
        .o_stick_right_y   (o_stick_right_y),
        .o_trigger_left    (o_trigger_left),
        .o_trigger_right   (o_trigger_right),
        .o_hat_direction   (o_hat_direction),
        .o_buttons_held    (o_buttons_held),
        .o_buttons_changed (o_buttons_changed)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // beat monitor
    always @(posedge i_clk) begin
        t_pad_state seen;
        if (i_rst_n) begin
            if (i_valid && o_ready)
                sb.note_beat(i_func, i_usage_page, i_usage, i_field_value);
            if (o_valid && i_ready) begin
                seen.left_x  = o_stick_left_x;
                seen.left_y  = o_stick_left_y;
                seen.right_x = o_stick_right_x;
                seen.right_y = o_stick_right_y;
                seen.trig_l  = o_trigger_left;
                seen.trig_r  = o_trigger_right;
                seen.hat     = o_hat_direction;
                seen.held    = o_buttons_held;
                seen.changed = o_buttons_changed;
                sb.check_result(seen);
            end
        end
    end

    // receiver stall pattern
    initial begin
        int ready_cyc;
        int mode;
        int hold_left;
        ready_cyc = 0;
        mode      = 0;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            ready_cyc++;
            if (ready_cyc % 64 == 0) mode = $urandom_range(0, 3);
            if (hold_left == 0 && holds_done < hold_requests) begin
                hold_left   = HOLD_CYCLES;
                holds_done++;
                hold_active = 1'b1;
            end
            if (hold_left > 0) begin
                i_ready <= 1'b0;
                hold_left--;
                if (hold_left == 0) hold_active = 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom_range(0, 1));
                    2: i_ready <= (ready_cyc % 5 != 0);
                    default: i_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle = 0;
            else idle++;
        end
        $display("FAIL gamepad_report_state_tracker_unit");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_beat(input logic [1:0] func, input logic [15:0] page,
                             input logic [15:0] usage, input logic [31:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 20);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (hold_active) gap = 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid       <= 1'b1;
        i_func        <= func;
        i_usage_page  <= page;
        i_usage       <= usage;
        i_field_value <= value;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    task automatic send_random_beat();
        logic [15:0] axis_codes [7];
        logic [1:0]  func;
        logic [15:0] page;
        logic [15:0] usage;
        logic [31:0] value;
        int          r;
        axis_codes = '{USAGE_X, USAGE_Y, USAGE_Z, USAGE_RX, USAGE_RY, USAGE_RZ, USAGE_HAT};
        r = $urandom_range(0, 99);
        if (r < 82)      func = FUNC_UPDATE;
        else if (r < 92) func = FUNC_READ;
        else if (r < 95) func = FUNC_RESET;
        else             func = FUNC_UNUSED;
        value = $urandom();
        r = $urandom_range(0, 99);
        if (r < 42) begin
            page = PAGE_DESKTOP;
            if ($urandom_range(0, 99) < 85) usage = axis_codes[$urandom_range(0, 6)];
            else usage = 16'($urandom());
        end else if (r < 84) begin
            page = PAGE_BUTTON;
            r = $urandom_range(0, 99);
            if (r < 80)      usage = 16'($urandom_range(1, BTN_LIMIT));
            else if (r < 85) usage = 16'd0;
            else if (r < 90) usage = 16'($urandom_range(BTN_LIMIT + 1, 32));
            else             usage = 16'($urandom());
            if ($urandom_range(0, 1) == 0) value = 32'd0;
        end else begin
            page  = 16'($urandom());
            usage = 16'($urandom());
        end
        send_beat(func, page, usage, value);
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_func        = FUNC_UPDATE;
        i_usage_page  = '0;
        i_usage       = '0;
        i_field_value = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed beats
        send_beat(FUNC_RESET,  16'h0000,     16'h0000,  32'h0000_0000);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, USAGE_X,   32'h0000_00FF);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, USAGE_Y,   32'h8000_0000);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, USAGE_Z,   32'h7FFF_FFFF);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, USAGE_RX,  32'hFFFF_FF01);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, USAGE_RY,  32'h1234_5680);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, USAGE_RZ,  32'hFFFF_FFFF);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, USAGE_HAT, 32'h0000_0007);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, USAGE_HAT, 32'hABCD_EFFE);
        send_beat(FUNC_UPDATE, PAGE_DESKTOP, 16'h0036,  32'h0000_0005);
        send_beat(FUNC_UPDATE, PAGE_BUTTON,  16'd1,     32'h0000_0001);
        send_beat(FUNC_UPDATE, PAGE_BUTTON,  16'(BTN_LIMIT), 32'h8000_0000);
        send_beat(FUNC_UPDATE, PAGE_BUTTON,  16'd1,     32'h0000_0100);
        send_beat(FUNC_READ,   16'hFFFF,     16'hFFFF,  32'hFFFF_FFFF);
        send_beat(FUNC_UPDATE, PAGE_BUTTON,  16'd1,     32'h0000_0000);
        send_beat(FUNC_UPDATE, PAGE_BUTTON,  16'd2,     32'h0000_0000);
        send_beat(FUNC_UPDATE, PAGE_BUTTON,  16'd0,     32'h0000_0001);
        send_beat(FUNC_UPDATE, PAGE_BUTTON,  16'(BTN_LIMIT + 1), 32'h0000_0001);
        send_beat(FUNC_UPDATE, PAGE_BUTTON,  16'hFFFF,  32'hFFFF_FFFF);
        send_beat(FUNC_UPDATE, 16'hFFFF,     USAGE_X,   32'h0000_0003);
        send_beat(FUNC_UPDATE, 16'h0000,     16'd1,     32'h0000_0001);
        send_beat(FUNC_UNUSED, PAGE_BUTTON,  16'd3,     32'h0000_0001);
        send_beat(FUNC_READ,   16'h0000,     16'h0000,  32'h0000_0000);
        send_beat(FUNC_READ,   PAGE_BUTTON,  16'd1,     32'h0000_0001);
        send_beat(FUNC_RESET,  PAGE_DESKTOP, USAGE_X,   32'h0000_0011);

        // random beats
        for (int n = 0; n < RANDOM_BEATS; n++) begin
            if (n == 200 || n == 550) hold_requests++;
            if (n == 400) drain_results();
            send_random_beat();
        end

        drain_results();
        repeat (8) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("PASS gamepad_report_state_tracker_unit");
        else
            $display("FAIL gamepad_report_state_tracker_unit");
        $finish;
    end

endmodule

>>> gamepad_report_state_tracker_unit.f
+incdir+rtl
rtl/grst_pkg.sv
rtl/gamepad_report_state_tracker_unit.sv
rtl/grst_checker.sv
tb/sv/grst_tb_pkg.sv
tb/sv/tb_top.sv
